// ----- rtl/ipt_pkg.sv -----
package ipt_pkg;

   // Default geometry of the frame store.
   localparam int FRAMES_DEF      = 32;
   localparam int FRAME_BYTES_DEF = 16;

   // Widths fixed by the item fields.
   localparam int OPCODE_W = 2;
   localparam int PID_W    = 8;
   localparam int PAGE_W   = 8;
   localparam int OFFSET_W = 4;
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 2;

   // Operation codes.
   localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_READ  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_FREE  = 2'd2;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_FRAME  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NO_ACCESS = 2'd2;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [PID_W-1:0]    pid;
      logic [PAGE_W-1:0]   page;
      logic [OFFSET_W-1:0] offset;
      logic [BYTE_W-1:0]   write_data;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   read_data;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOKUP,
      S_DECIDE,
      S_CLEAR,
      S_WRITE,
      S_READ,
      S_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic req_load;
      logic lookup;
      logic decide;
      logic claim;
      logic free_pid;
      logic clear_step;
      logic mem_write;
      logic mem_read;
      logic rsp_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_write;
      logic is_read;
      logic is_free;
      logic pid_zero;
      logic hit;
      logic any_free;
      logic clear_last;
      logic rsp_ready;
   } stat_type;

endpackage

// ----- rtl/ipt_ctrl.sv -----
module ipt_ctrl import ipt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   // A write that goes on to store a byte: a hit, or a miss with a frame to claim.
   logic write_go;
   assign write_go = stat.is_write && !stat.pid_zero && (stat.hit || stat.any_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_LOOKUP;
         end
         S_LOOKUP: state_in = S_DECIDE;
         S_DECIDE: begin
            if (write_go && stat.hit)           state_in = S_WRITE;
            else if (write_go)                  state_in = S_CLEAR;
            else if (stat.is_read && stat.hit)  state_in = S_READ;
            else                                state_in = S_DONE;
         end
         S_CLEAR: begin
            if (stat.clear_last) state_in = S_WRITE;
         end
         S_WRITE: state_in = S_DONE;
         S_READ:  state_in = S_DONE;
         S_DONE: begin
            if (stat.rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall    = 1'b0;
            cmd.req_load = req_valid;
         end
         S_LOOKUP: cmd.lookup = 1'b1;
         S_DECIDE: begin
            cmd.decide   = 1'b1;
            cmd.claim    = write_go && !stat.hit;
            cmd.free_pid = stat.is_free;
         end
         S_CLEAR: cmd.clear_step = 1'b1;
         S_WRITE: cmd.mem_write  = 1'b1;
         S_READ:  cmd.mem_read   = 1'b1;
         S_DONE:  cmd.rsp_load   = stat.rsp_ready;
         default: cmd = '0;
      endcase
   end

endmodule

// ----- rtl/ipt_dpath.sv -----
module ipt_dpath import ipt_pkg::*; #(
   parameter int FRAMES      = FRAMES_DEF,
   parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_item,
   input  logic     rsp_stall,
   output logic     rsp_valid,
   output rsp_type  rsp_item,
   input  cmd_type  cmd,
   output stat_type stat
);

   localparam int FW    = $clog2(FRAMES);
   localparam int OW    = $clog2(FRAME_BYTES);
   localparam int DEPTH = FRAMES * FRAME_BYTES;
   localparam int AW    = $clog2(DEPTH);
   localparam int OFFS  = 2 ** OFFSET_W;

   // Request register.
   req_type req_ff;

   // Inverted page table: owner per frame (zero is free) and page per frame.
   logic [PID_W-1:0]  owner_ff [FRAMES];
   logic [PAGE_W-1:0] page_ff  [FRAMES];

   // Registered match vectors from the lookup step.
   logic [FRAMES-1:0] match_ff;
   logic [FRAMES-1:0] own_ff;
   logic [FRAMES-1:0] free_ff;
   logic [FRAMES-1:0] match_in;
   logic [FRAMES-1:0] own_in;
   logic [FRAMES-1:0] free_in;

   logic [FW-1:0] hit_idx;
   logic [FW-1:0] free_idx;
   logic [FW-1:0] frame_ff;
   logic [OW-1:0] clr_cnt_ff;

   // Byte store.
   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] mem_rdata_ff;

   logic [OW-1:0] off_mod [OFFS];
   logic [AW-1:0] base_addr;
   logic [AW-1:0] mem_addr;
   logic [BYTE_W-1:0] mem_wdata;

   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_item_ff;
   rsp_type rsp_item_in;

   logic pid_zero;
   assign pid_zero = (req_ff.pid == '0);

   // Offset reduced modulo the frame size, as a constant table.
   for (genvar i = 0; i < OFFS; i++) begin : g_off
      assign off_mod[i] = OW'(i % FRAME_BYTES);
   end

   for (genvar f = 0; f < FRAMES; f++) begin : g_lane
      assign own_in[f]   = !pid_zero && (owner_ff[f] == req_ff.pid);
      assign match_in[f] = own_in[f] && (page_ff[f] == req_ff.page);
      assign free_in[f]  = (owner_ff[f] == '0);
   end

   // Lowest set bit of each registered vector.
   always_comb begin
      hit_idx  = '0;
      free_idx = '0;
      for (int f = FRAMES - 1; f >= 0; f--) begin
         if (match_ff[f]) hit_idx  = FW'(f);
         if (free_ff[f])  free_idx = FW'(f);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.req_load) req_ff <= req_item;
      if (cmd.lookup) begin
         match_ff <= match_in;
         own_ff   <= own_in;
         free_ff  <= free_in;
      end
      if (cmd.decide) begin
         frame_ff   <= (|match_ff) ? hit_idx : free_idx;
         clr_cnt_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_cnt_ff <= clr_cnt_ff + OW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int f = 0; f < FRAMES; f++) owner_ff[f] <= '0;
      end else if (cmd.claim) begin
         owner_ff[free_idx] <= req_ff.pid;
      end else if (cmd.free_pid) begin
         for (int f = 0; f < FRAMES; f++) begin
            if (own_ff[f]) owner_ff[f] <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.claim) page_ff[free_idx] <= req_ff.page;
   end

   assign base_addr = AW'(frame_ff) * AW'(FRAME_BYTES);
   assign mem_addr  = cmd.clear_step ? base_addr + AW'(clr_cnt_ff)
                                     : base_addr + AW'(off_mod[req_ff.offset]);
   assign mem_wdata = cmd.clear_step ? '0 : req_ff.write_data;

   always_ff @(posedge clock) begin
      if (cmd.clear_step || cmd.mem_write) mem[mem_addr] <= mem_wdata;
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_read) mem_rdata_ff <= mem[mem_addr];
   end

   // Result item.
   always_comb begin
      rsp_item_in.read_data = '0;
      rsp_item_in.status    = ST_OK;
      case (req_ff.opcode)
         OP_WRITE: begin
            if (pid_zero)                    rsp_item_in.status = ST_NO_ACCESS;
            else if (!(|match_ff || |free_ff)) rsp_item_in.status = ST_NO_FRAME;
         end
         OP_READ: begin
            if (|match_ff) rsp_item_in.read_data = mem_rdata_ff;
            else           rsp_item_in.status    = ST_NO_ACCESS;
         end
         default: rsp_item_in.status = ST_OK;
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   assign stat.is_write   = (req_ff.opcode == OP_WRITE);
   assign stat.is_read    = (req_ff.opcode == OP_READ);
   assign stat.is_free    = (req_ff.opcode == OP_FREE);
   assign stat.pid_zero   = pid_zero;
   assign stat.hit        = |match_ff;
   assign stat.any_free   = |free_ff;
   assign stat.clear_last = (clr_cnt_ff == OW'(FRAME_BYTES - 1));
   assign stat.rsp_ready  = !rsp_valid_ff || !rsp_stall;

endmodule

// ----- rtl/inverted_page_table_ram.sv -----
// Byte memory of FRAMES frames of FRAME_BYTES bytes, mapped through an inverted page
// table: each frame records its owning process id (zero means free) and a virtual page
// number, and a write, read or free item is looked up against all frames at once with
// one comparator per frame. Every item produces exactly one result item. A controller
// takes one item at a time: the item is registered, the tag match is registered, the
// frame is chosen, then at most one access to the single-port byte RAM follows, besides
// the clearing sweep of a claimed frame, and the result goes into an output register.
// A write that claims a new frame first zeroes that frame through the RAM write port,
// one byte per cycle. Because a frame is zeroed when it is claimed, no clearing pass is
// needed after reset and freeing a process only drops its owner tags. The next item is
// accepted while a finished result still waits in the output register; only the
// completion of the following item waits for it.
module inverted_page_table_ram import ipt_pkg::*; #(
   parameter int FRAMES      = FRAMES_DEF,
   parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_item
);

   // Command and status between the controller and the datapath.
   cmd_type  cmd;
   stat_type stat;

   // The controller sequences lookup, frame choice, clearing sweep and RAM access.
   ipt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the tags, the byte RAM and the output register.
   ipt_dpath #(
      .FRAMES      (FRAMES),
      .FRAME_BYTES (FRAME_BYTES)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

// ----- sim/tb_inverted_page_table_ram.sv -----
module tb_inverted_page_table_ram import ipt_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   // Geometry of the block under test, taken from the package defaults.
   localparam int FRAMES      = FRAMES_DEF;
   localparam int FRAME_BYTES = FRAME_BYTES_DEF;

   // The opcode field is two bits wide, so one value is left without a meaning.
   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS  = 680;
   localparam int PHASE_ITEMS   = 50;
   localparam int HOLDOFF_AFTER = 300;
   localparam int HOLDOFF_LEN   = 400;
   localparam int DRAIN_CYCLES  = 40;
   localparam int CYCLE_LIMIT   = 150000;
   localparam int MAX_REPORTS   = 10;

   // Idling pattern. The run walks through these phases over and over, a
   // new phase every PHASE_ITEMS accepted items, so that gaps and stalls
   // land on every step of the controller's work.
   typedef enum logic [1:0] {
      PH_STEADY,
      PH_SENDER_GAPS,
      PH_RECEIVER_STALLS,
      PH_BOTH_IDLE
   } idle_phase_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_item  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_item;

   inverted_page_table_ram u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always #6 clock = ~clock;

   // Items waiting to be offered, and results owed by the block in order.
   req_type items_to_send[$];
   rsp_type replies_due[$];

   // Our own copy of the page table and the byte store.
   logic [PID_W-1:0]  owner_of_frame[FRAMES];
   logic [PAGE_W-1:0] page_of_frame[FRAMES];
   logic [BYTE_W-1:0] frame_store[FRAMES*FRAME_BYTES];

   int items_accepted = 0;
   int replies_checked = 0;
   int mismatches = 0;
   int cycle_count = 0;
   int holdoff_left = 0;
   bit holdoff_done = 1'b0;

   // What the run went through, for the closing summary.
   int n_write = 0, n_claim = 0, n_read = 0, n_read_hit = 0;
   int n_free = 0, n_unused = 0, n_no_frame = 0, n_no_access = 0;

   // Apply one item to the page table copy and return the result the block
   // owes for it. A frame matches only when both its owner and its page
   // agree with the item. A free frame always holds zero bytes, because a
   // release wipes the bytes of every frame it drops.
   function automatic rsp_type page_table_access(input req_type it);
      rsp_type r;
      int      hit_frame;
      int      free_frame;
      int      f;
      r = '0;
      r.status = ST_OK;
      hit_frame = -1;
      free_frame = -1;
      // Scanning downward leaves the lowest matching and lowest free frame.
      for (f = FRAMES - 1; f >= 0; f--) begin
         if (it.pid != 0 && owner_of_frame[f] == it.pid && page_of_frame[f] == it.page)
            hit_frame = f;
         if (owner_of_frame[f] == 0)
            free_frame = f;
      end
      case (it.opcode)
         OP_WRITE: begin
            n_write++;
            if (it.pid == 0) begin
               r.status = ST_NO_ACCESS;
            end else if (hit_frame < 0 && free_frame < 0) begin
               r.status = ST_NO_FRAME;
            end else begin
               if (hit_frame < 0) begin
                  hit_frame = free_frame;
                  owner_of_frame[hit_frame] = it.pid;
                  page_of_frame[hit_frame] = it.page;
                  n_claim++;
               end
               frame_store[hit_frame*FRAME_BYTES + it.offset] = it.write_data;
            end
         end
         OP_READ: begin
            n_read++;
            if (hit_frame < 0) begin
               r.status = ST_NO_ACCESS;
            end else begin
               r.read_data = frame_store[hit_frame*FRAME_BYTES + it.offset];
               n_read_hit++;
            end
         end
         OP_FREE: begin
            n_free++;
            if (it.pid != 0) begin
               for (f = 0; f < FRAMES; f++) begin
                  if (owner_of_frame[f] == it.pid) begin
                     owner_of_frame[f] = '0;
                     for (int b = 0; b < FRAME_BYTES; b++)
                        frame_store[f*FRAME_BYTES + b] = '0;
                  end
               end
            end
         end
         default: begin
            n_unused++;
         end
      endcase
      if (r.status == ST_NO_FRAME)
         n_no_frame++;
      if (r.status == ST_NO_ACCESS)
         n_no_access++;
      return r;
   endfunction

   // Chance in percent that a side idles in a given cycle. It follows the
   // item count, which only changes at clock edges through a nonblocking
   // assignment, so every process sees the same phase.
   function automatic int idle_percent(input bit sender_side);
      idle_phase_type phase;
      phase = idle_phase_type'((items_accepted / PHASE_ITEMS) % 4);
      case (phase)
         PH_SENDER_GAPS:     return sender_side ? 48 : 0;
         PH_RECEIVER_STALLS: return sender_side ? 0 : 48;
         PH_BOTH_IDLE:       return 7;
         default:            return 0;
      endcase
   endfunction

   task automatic queue_item(input logic [OPCODE_W-1:0] op, input logic [PID_W-1:0] pid,
                             input logic [PAGE_W-1:0] page,
                             input logic [OFFSET_W-1:0] offset,
                             input logic [BYTE_W-1:0] data);
      req_type it;
      it.opcode = op;
      it.pid = pid;
      it.page = page;
      it.offset = offset;
      it.write_data = data;
      items_to_send.push_back(it);
   endtask

   // Driver. A new item goes out only when the channel is empty or the item
   // on it is being taken at this edge; a stalled item is held unchanged.
   // Whether the next cycle is a gap is drawn at random, never from stall.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (items_to_send.size() > 0 && $urandom_range(99) >= idle_percent(1'b1)) begin
            req_item <= items_to_send.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver stall. Most of the time it is a random draw per cycle. Once,
   // some way into the run, the receiver holds off for a long stretch while
   // the driver keeps offering, so the block fills and stalls its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (holdoff_left > 0) begin
         holdoff_left <= holdoff_left - 1;
         rsp_stall <= 1'b1;
      end else if (!holdoff_done && items_accepted >= HOLDOFF_AFTER) begin
         holdoff_done <= 1'b1;
         holdoff_left <= HOLDOFF_LEN;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < idle_percent(1'b0));
      end
   end

   // Monitor. Both handshakes are sampled at the same edge. The result is
   // checked first, so an item taken at this edge can never stand in for a
   // result that arrives at the same edge.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (replies_due.size() == 0) begin
               if (mismatches < MAX_REPORTS)
                  $display("%0t: result with nothing outstanding: read_data %h status %0d",
                           $realtime, rsp_item.read_data, rsp_item.status);
               mismatches++;
            end else begin
               want = replies_due.pop_front();
               if (rsp_item.read_data !== want.read_data || rsp_item.status !== want.status) begin
                  if (mismatches < MAX_REPORTS)
                     $display("%0t: result %0d wrong: read_data %h status %0d, expected %h / %0d",
                              $realtime, replies_checked, rsp_item.read_data, rsp_item.status,
                              want.read_data, want.status);
                  mismatches++;
               end
               replies_checked++;
            end
         end
         if (req_valid && !req_stall) begin
            replies_due.push_back(page_table_access(req_item));
            items_accepted <= items_accepted + 1;
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      logic [OPCODE_W-1:0] op;
      logic [PID_W-1:0]    pid;
      logic [PAGE_W-1:0]   page;
      logic [PID_W-1:0]    stray_pids[$];
      int                  roll;

      for (int f = 0; f < FRAMES; f++) begin
         owner_of_frame[f] = '0;
         page_of_frame[f] = '0;
      end
      for (int b = 0; b < FRAMES*FRAME_BYTES; b++)
         frame_store[b] = '0;

      // Directed items. A read of an empty table misses, the first write
      // claims frame zero, and the corners of every field are exercised.
      queue_item(OP_READ,  8'd1,   8'd0,   4'd0,  8'h00);
      queue_item(OP_WRITE, 8'd1,   8'd0,   4'd0,  8'hA5);
      queue_item(OP_READ,  8'd1,   8'd0,   4'd0,  8'h00);
      queue_item(OP_WRITE, 8'd255, 8'd255, 4'd15, 8'hFF);
      queue_item(OP_READ,  8'd255, 8'd255, 4'd15, 8'h00);
      // A freshly claimed frame reads back zero away from the written byte.
      queue_item(OP_READ,  8'd255, 8'd255, 4'd0,  8'h00);
      // Same page under another owner must not match.
      queue_item(OP_READ,  8'd1,   8'd255, 4'd15, 8'h00);
      queue_item(OP_WRITE, 8'd2,   8'd0,   4'd5,  8'h5A);
      queue_item(OP_READ,  8'd1,   8'd0,   4'd0,  8'h00);
      queue_item(OP_READ,  8'd2,   8'd0,   4'd5,  8'h00);
      // A second write to a mapped page hits without claiming.
      queue_item(OP_WRITE, 8'd1,   8'd0,   4'd10, 8'h3C);
      queue_item(OP_READ,  8'd1,   8'd0,   4'd10, 8'h00);
      // Process id zero on every operation, and the unused opcode.
      queue_item(OP_WRITE, 8'd0,   8'd0,   4'd0,  8'h77);
      queue_item(OP_READ,  8'd0,   8'd0,   4'd0,  8'h00);
      queue_item(OP_FREE,  8'd0,   8'd0,   4'd0,  8'h00);
      queue_item(OP_UNUSED, 8'hAA, 8'h55,  4'd9,  8'hC3);
      // Freeing a process that owns nothing, then one that owns a frame;
      // its bytes are gone and a new claim starts from zero.
      queue_item(OP_FREE,  8'd7,   8'd0,   4'd0,  8'h00);
      queue_item(OP_FREE,  8'd1,   8'd0,   4'd0,  8'h00);
      queue_item(OP_READ,  8'd1,   8'd0,   4'd0,  8'h00);
      queue_item(OP_WRITE, 8'd1,   8'd0,   4'd1,  8'h81);
      queue_item(OP_READ,  8'd1,   8'd0,   4'd0,  8'h00);
      queue_item(OP_READ,  8'd1,   8'd0,   4'd1,  8'h00);

      // Random items. Most use a handful of processes over a handful of
      // pages, which is more pairs than there are frames, so lookups hit
      // often and the table runs full now and then. The rest is noise over
      // the full range of every field. Processes that noise gave frames to
      // are released from time to time so the table does not silt up.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         roll = $urandom_range(99);
         pid = PID_W'($urandom_range(1, 6));
         page = PAGE_W'($urandom_range(0, 7));
         if (n % 64 == 63) begin
            while (stray_pids.size() > 0)
               queue_item(OP_FREE, stray_pids.pop_front(), PAGE_W'($urandom),
                          OFFSET_W'($urandom), BYTE_W'($urandom));
         end else if (roll < 45) begin
            queue_item(OP_WRITE, pid, page, OFFSET_W'($urandom), BYTE_W'($urandom));
         end else if (roll < 83) begin
            queue_item(OP_READ, pid, page, OFFSET_W'($urandom), BYTE_W'($urandom));
         end else if (roll < 88) begin
            queue_item(OP_FREE, pid, PAGE_W'($urandom), OFFSET_W'($urandom),
                       BYTE_W'($urandom));
         end else begin
            op = OPCODE_W'($urandom_range(0, 3));
            pid = PID_W'($urandom_range(0, 255));
            if (op == OP_WRITE && pid != 0)
               stray_pids.push_back(pid);
            queue_item(op, pid, PAGE_W'($urandom), OFFSET_W'($urandom), BYTE_W'($urandom));
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Wait until every item has been taken and every result has come,
      // then give the block a little longer to show any stray result.
      while (items_to_send.size() > 0 || req_valid)
         @(posedge clock);
      while (replies_due.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d items, %0d results checked, %0d mismatches: %0d writes (%0d new frames),",
               items_accepted, replies_checked, mismatches, n_write, n_claim);
      $display("%0d reads (%0d hits), %0d frees, %0d unused opcodes, %0d table full, %0d denied",
               n_read, n_read_hit, n_free, n_unused, n_no_frame, n_no_access);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
